>>> hw/rtl/psrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proportional share rate limiter package
// Shared widths, codes, records and the sequencer state type.
// ----------------------------------------------------------------------------
package psrl_pkg;

    localparam int RATE_W         = 48;
    localparam int TIME_W         = 32;
    localparam int BYTE_W         = 32;
    localparam int WEIGHT_W       = 17;
    localparam int TRIG_W         = 16;
    localparam int MODE_W         = 2;
    localparam int FLOW_W         = 4;
    localparam int HALF_W         = 24;
    localparam int PROD_W         = 2 * HALF_W;
    localparam int ACC_W          = 96;
    localparam int STEP_W         = 7;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 64;

    localparam int FLOW_SLOTS_DEF = 16;
    localparam int RATE_FRAC_DEF  = 16;

    localparam logic [RATE_W-1:0]   RATE_MAX   = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    localparam logic [RATE_W-1:0]   RST_RATE_CAP = '1;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT   = 17'd6554;
    localparam logic [TRIG_W-1:0]   RST_TRIGGER  = 16'd512;

    localparam logic [MODE_W-1:0] MODE_OFFER   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEND    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    localparam logic [1:0] CFG_RATE_CAP = 2'd0;
    localparam logic [1:0] CFG_WEIGHT   = 2'd1;
    localparam logic [1:0] CFG_TRIGGER  = 2'd2;
    localparam logic [1:0] CFG_LIMIT_EN = 2'd3;

    localparam logic [1:0] MAC_SH0  = 2'd0;
    localparam logic [1:0] MAC_SH24 = 2'd1;
    localparam logic [1:0] MAC_SH48 = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0] offered;
        logic [RATE_W-1:0] allowed;
        logic [RATE_W-1:0] send;
        logic [TIME_W-1:0] t_offer;
        logic [TIME_W-1:0] t_send;
    } t_flow_rec;

    typedef struct packed {
        logic              vld;
        logic              clr;
        logic [HALF_W-1:0] a;
        logic [HALF_W-1:0] b;
        logic [1:0]        sh;
    } t_mac_op;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_THR_MAC,
        ST_THR_END,
        ST_THR_CMP,
        ST_DIV,
        ST_DIV_WAIT,
        ST_BLD_MAC,
        ST_BLD_END,
        ST_BLD_RES,
        ST_SHR_CHK,
        ST_SHR_MAC,
        ST_SHR_END,
        ST_SHR_DIV,
        ST_SHR_WAIT,
        ST_WRITE,
        ST_OUT
    } t_state;

endpackage

>>> hw/rtl/proportional_share_rate_limiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proportional share rate limiter unit
// Per-flow offered and send rate averages held in a flow table, with the
// allowed rate shared in proportion to each flow's offered rate.
//
//   Channel   Handshake                         Payload
//   config    psel/penable/pwrite, pready = 1   paddr, pwdata, prdata
//   command   start while busy is low           i_mode, i_flow_id,
//                                               i_byte_count, i_time_now
//   result    o_valid, one cycle                o_grant, o_share_rate
//
// One item at a time; busy is high from acceptance through the result cycle.
// Offers and sends pass through the iterative divider (one quotient bit per
// cycle), whose step count for the measured rate grows with RATE_FRAC_BITS;
// an offer whose total exceeds the cap uses it a second time. Releases and
// unused modes do not use the divider.
// Reset is synchronous and clears the flow table through its valid bits.
// The result is shown for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module proportional_share_rate_limiter_unit #(
    parameter int FLOW_SLOTS     = psrl_pkg::FLOW_SLOTS_DEF,
    parameter int RATE_FRAC_BITS = psrl_pkg::RATE_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [psrl_pkg::PADDR_W-1:0]      paddr,
    input  logic [psrl_pkg::PDATA_W-1:0]      pwdata,
    output logic [psrl_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [psrl_pkg::MODE_W-1:0]       i_mode,
    input  logic [psrl_pkg::FLOW_W-1:0]       i_flow_id,
    input  logic [psrl_pkg::BYTE_W-1:0]       i_byte_count,
    input  logic [psrl_pkg::TIME_W-1:0]       i_time_now,
    output logic                              o_valid,
    output logic                              o_grant,
    output logic [psrl_pkg::RATE_W-1:0]       o_share_rate
);

    localparam int IDX_W   = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int TOTAL_W = psrl_pkg::RATE_W + $clog2(FLOW_SLOTS);
    localparam int RW      = psrl_pkg::RATE_W;
    localparam int HW      = psrl_pkg::HALF_W;

    psrl_pkg::t_state                 r_state, n_state;

    logic [RW-1:0]                    r_rate_cap;
    logic [psrl_pkg::WEIGHT_W-1:0]    r_weight;
    logic [psrl_pkg::TRIG_W-1:0]      r_trig;
    logic                             r_limit_en;

    logic [psrl_pkg::MODE_W-1:0]      r_mode;
    logic [IDX_W-1:0]                 r_idx;
    logic [psrl_pkg::BYTE_W-1:0]      r_bytes;
    logic [psrl_pkg::TIME_W-1:0]      r_now;
    psrl_pkg::t_flow_rec              r_rec;
    logic [RW-1:0]                    r_base;
    logic [RW-1:0]                    r_inst;
    logic [RW-1:0]                    r_new;
    logic [RW-1:0]                    r_allowed_out;
    logic                             r_grant;
    logic [TOTAL_W-1:0]               r_total;
    logic [1:0]                       r_mcnt;

    logic                             accept;
    logic                             in_range;
    logic                             cfg_wr;
    logic [1:0]                       cfg_idx;

    psrl_pkg::t_flow_rec              tbl_rec;
    psrl_pkg::t_flow_rec              wr_rec;
    logic                             tbl_rd_en;
    logic                             tbl_wr_en;
    psrl_pkg::t_mac_op                mac_op;
    logic [psrl_pkg::ACC_W-1:0]       mac_acc;
    psrl_pkg::t_div_cmd               div_cmd;
    logic [TOTAL_W-1:0]               div_divisor;
    logic                             div_done;
    logic [psrl_pkg::ACC_W-1:0]       div_quot;

    logic [psrl_pkg::WEIGHT_W-1:0]    w_sat;
    logic [psrl_pkg::WEIGHT_W-1:0]    k_wt;
    logic [psrl_pkg::TIME_W-1:0]      elapsed;
    logic [psrl_pkg::TIME_W-1:0]      elapsed1;
    logic [RW-1:0]                    blend;
    logic [RW-1:0]                    quot_sat;
    logic [TOTAL_W-1:0]               total_upd;
    logic [TOTAL_W-1:0]               cap_ext;
    logic                             thr_hit;
    logic                             mac_state;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_cap <= psrl_pkg::RST_RATE_CAP;
            r_weight   <= psrl_pkg::RST_WEIGHT;
            r_trig     <= psrl_pkg::RST_TRIGGER;
            r_limit_en <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                psrl_pkg::CFG_RATE_CAP: r_rate_cap <= pwdata[RW-1:0];
                psrl_pkg::CFG_WEIGHT:   r_weight   <= pwdata[psrl_pkg::WEIGHT_W-1:0];
                psrl_pkg::CFG_TRIGGER:  r_trig     <= pwdata[psrl_pkg::TRIG_W-1:0];
                psrl_pkg::CFG_LIMIT_EN: r_limit_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            psrl_pkg::CFG_RATE_CAP: prdata = psrl_pkg::PDATA_W'(r_rate_cap);
            psrl_pkg::CFG_WEIGHT:   prdata = psrl_pkg::PDATA_W'(r_weight);
            psrl_pkg::CFG_TRIGGER:  prdata = psrl_pkg::PDATA_W'(r_trig);
            psrl_pkg::CFG_LIMIT_EN: prdata = psrl_pkg::PDATA_W'(r_limit_en);
            default:                prdata = '0;
        endcase
    end

    // Datapath helpers
    assign busy     = (r_state != psrl_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(i_flow_id) < FLOW_SLOTS);

    always_comb begin
        w_sat     = (r_weight > psrl_pkg::WEIGHT_ONE) ? psrl_pkg::WEIGHT_ONE : r_weight;
        k_wt      = psrl_pkg::WEIGHT_ONE - w_sat;
        elapsed   = r_now - ((r_mode == psrl_pkg::MODE_OFFER) ? r_rec.t_offer : r_rec.t_send);
        elapsed1  = (elapsed == '0) ? psrl_pkg::TIME_W'(1) : elapsed;
        blend     = mac_acc[16 +: RW];
        quot_sat  = (|div_quot[psrl_pkg::ACC_W-1:RW]) ? psrl_pkg::RATE_MAX
                                                      : div_quot[RW-1:0];
        total_upd = r_total - TOTAL_W'(r_rec.offered) + TOTAL_W'(blend);
        cap_ext   = TOTAL_W'(r_rate_cap);
        thr_hit   = 64'({r_rec.send, 8'b0}) > mac_acc[63:0];
        mac_state = (r_state == psrl_pkg::ST_THR_MAC) || (r_state == psrl_pkg::ST_BLD_MAC)
                 || (r_state == psrl_pkg::ST_SHR_MAC);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psrl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = in_range ? psrl_pkg::ST_READ : psrl_pkg::ST_OUT;
                end
            end
            psrl_pkg::ST_READ: begin
                case (r_mode)
                    psrl_pkg::MODE_OFFER:   n_state = psrl_pkg::ST_DIV;
                    psrl_pkg::MODE_SEND:    n_state = psrl_pkg::ST_THR_MAC;
                    psrl_pkg::MODE_RELEASE: n_state = psrl_pkg::ST_WRITE;
                    default:                n_state = psrl_pkg::ST_OUT;
                endcase
            end
            psrl_pkg::ST_THR_MAC: begin
                if (r_mcnt == 2'd1) begin
                    n_state = psrl_pkg::ST_THR_END;
                end
            end
            psrl_pkg::ST_THR_END:  n_state = psrl_pkg::ST_THR_CMP;
            psrl_pkg::ST_THR_CMP:  n_state = psrl_pkg::ST_DIV;
            psrl_pkg::ST_DIV:      n_state = psrl_pkg::ST_DIV_WAIT;
            psrl_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = psrl_pkg::ST_BLD_MAC;
                end
            end
            psrl_pkg::ST_BLD_MAC: begin
                if (r_mcnt == 2'd3) begin
                    n_state = psrl_pkg::ST_BLD_END;
                end
            end
            psrl_pkg::ST_BLD_END:  n_state = psrl_pkg::ST_BLD_RES;
            psrl_pkg::ST_BLD_RES: begin
                n_state = (r_mode == psrl_pkg::MODE_OFFER) ? psrl_pkg::ST_SHR_CHK
                                                           : psrl_pkg::ST_WRITE;
            end
            psrl_pkg::ST_SHR_CHK: begin
                if (r_total == '0 || r_rate_cap == psrl_pkg::RATE_MAX || r_total <= cap_ext) begin
                    n_state = psrl_pkg::ST_WRITE;
                end else begin
                    n_state = psrl_pkg::ST_SHR_MAC;
                end
            end
            psrl_pkg::ST_SHR_MAC: begin
                if (r_mcnt == 2'd3) begin
                    n_state = psrl_pkg::ST_SHR_END;
                end
            end
            psrl_pkg::ST_SHR_END:  n_state = psrl_pkg::ST_SHR_DIV;
            psrl_pkg::ST_SHR_DIV:  n_state = psrl_pkg::ST_SHR_WAIT;
            psrl_pkg::ST_SHR_WAIT: begin
                if (div_done) begin
                    n_state = psrl_pkg::ST_WRITE;
                end
            end
            psrl_pkg::ST_WRITE:    n_state = psrl_pkg::ST_OUT;
            psrl_pkg::ST_OUT:      n_state = psrl_pkg::ST_IDLE;
            default:               n_state = psrl_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        tbl_rd_en        = 1'b0;
        tbl_wr_en        = 1'b0;
        mac_op           = '0;
        div_cmd          = '0;
        div_divisor      = TOTAL_W'(elapsed1);
        o_valid          = 1'b0;
        wr_rec           = '0;
        unique case (r_state)
            psrl_pkg::ST_IDLE: begin
                tbl_rd_en = accept && in_range;
            end
            psrl_pkg::ST_THR_MAC: begin
                mac_op.vld = 1'b1;
                mac_op.clr = (r_mcnt == 2'd0);
                mac_op.b   = HW'(r_trig);
                if (r_mcnt == 2'd0) begin
                    mac_op.a  = r_rec.allowed[HW-1:0];
                    mac_op.sh = psrl_pkg::MAC_SH0;
                end else begin
                    mac_op.a  = r_rec.allowed[RW-1:HW];
                    mac_op.sh = psrl_pkg::MAC_SH24;
                end
            end
            psrl_pkg::ST_DIV: begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = {r_bytes, 64'b0};
                div_cmd.steps    = psrl_pkg::STEP_W'(psrl_pkg::BYTE_W + RATE_FRAC_BITS);
            end
            psrl_pkg::ST_BLD_MAC: begin
                mac_op.vld = 1'b1;
                mac_op.clr = (r_mcnt == 2'd0);
                case (r_mcnt)
                    2'd0: begin
                        mac_op.a  = r_base[HW-1:0];
                        mac_op.b  = HW'(k_wt);
                        mac_op.sh = psrl_pkg::MAC_SH0;
                    end
                    2'd1: begin
                        mac_op.a  = r_base[RW-1:HW];
                        mac_op.b  = HW'(k_wt);
                        mac_op.sh = psrl_pkg::MAC_SH24;
                    end
                    2'd2: begin
                        mac_op.a  = r_inst[HW-1:0];
                        mac_op.b  = HW'(w_sat);
                        mac_op.sh = psrl_pkg::MAC_SH0;
                    end
                    default: begin
                        mac_op.a  = r_inst[RW-1:HW];
                        mac_op.b  = HW'(w_sat);
                        mac_op.sh = psrl_pkg::MAC_SH24;
                    end
                endcase
            end
            psrl_pkg::ST_SHR_MAC: begin
                mac_op.vld = 1'b1;
                mac_op.clr = (r_mcnt == 2'd0);
                case (r_mcnt)
                    2'd0: begin
                        mac_op.a  = r_new[HW-1:0];
                        mac_op.b  = r_rate_cap[HW-1:0];
                        mac_op.sh = psrl_pkg::MAC_SH0;
                    end
                    2'd1: begin
                        mac_op.a  = r_new[HW-1:0];
                        mac_op.b  = r_rate_cap[RW-1:HW];
                        mac_op.sh = psrl_pkg::MAC_SH24;
                    end
                    2'd2: begin
                        mac_op.a  = r_new[RW-1:HW];
                        mac_op.b  = r_rate_cap[HW-1:0];
                        mac_op.sh = psrl_pkg::MAC_SH24;
                    end
                    default: begin
                        mac_op.a  = r_new[RW-1:HW];
                        mac_op.b  = r_rate_cap[RW-1:HW];
                        mac_op.sh = psrl_pkg::MAC_SH48;
                    end
                endcase
            end
            psrl_pkg::ST_SHR_DIV: begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = mac_acc;
                div_cmd.steps    = psrl_pkg::STEP_W'(psrl_pkg::ACC_W);
                div_divisor      = r_total;
            end
            psrl_pkg::ST_WRITE: begin
                tbl_wr_en = 1'b1;
                case (r_mode)
                    psrl_pkg::MODE_OFFER: begin
                        wr_rec.offered = r_new;
                        wr_rec.allowed = r_allowed_out;
                        wr_rec.send    = r_rec.send;
                        wr_rec.t_offer = r_now;
                        wr_rec.t_send  = r_rec.t_send;
                    end
                    psrl_pkg::MODE_SEND: begin
                        wr_rec.offered = r_rec.offered;
                        wr_rec.allowed = r_rec.allowed;
                        wr_rec.send    = r_grant ? r_new : r_base;
                        wr_rec.t_offer = r_rec.t_offer;
                        wr_rec.t_send  = r_grant ? r_now : r_rec.t_send;
                    end
                    default: wr_rec = '0;
                endcase
            end
            psrl_pkg::ST_OUT: begin
                o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psrl_pkg::ST_IDLE;
            r_total <= '0;
            r_mcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_mcnt  <= mac_state ? r_mcnt + 2'd1 : 2'd0;
            if (r_state == psrl_pkg::ST_READ && r_mode == psrl_pkg::MODE_RELEASE) begin
                r_total <= r_total - TOTAL_W'(tbl_rec.offered);
            end
            if (r_state == psrl_pkg::ST_BLD_RES && r_mode == psrl_pkg::MODE_OFFER) begin
                r_total <= total_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            psrl_pkg::ST_IDLE: begin
                if (accept) begin
                    r_mode        <= i_mode;
                    r_idx         <= IDX_W'(i_flow_id);
                    r_bytes       <= i_byte_count;
                    r_now         <= i_time_now;
                    r_grant       <= 1'b1;
                    r_allowed_out <= '0;
                end
            end
            psrl_pkg::ST_READ: begin
                r_rec         <= tbl_rec;
                r_base        <= tbl_rec.offered;
                r_allowed_out <= (r_mode == psrl_pkg::MODE_RELEASE) ? '0 : tbl_rec.allowed;
            end
            psrl_pkg::ST_THR_CMP: begin
                r_base <= thr_hit ? '0 : r_rec.send;
            end
            psrl_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    r_inst <= quot_sat;
                end
            end
            psrl_pkg::ST_BLD_RES: begin
                r_new <= blend;
                if (r_mode == psrl_pkg::MODE_SEND) begin
                    r_grant <= (blend <= r_rec.allowed) || !r_limit_en;
                end
            end
            psrl_pkg::ST_SHR_CHK: begin
                if (r_total == '0) begin
                    r_allowed_out <= '0;
                end else if (r_rate_cap == psrl_pkg::RATE_MAX || r_total <= cap_ext) begin
                    r_allowed_out <= r_new;
                end
            end
            psrl_pkg::ST_SHR_WAIT: begin
                if (div_done) begin
                    r_allowed_out <= div_quot[RW-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_grant      = r_grant;
    assign o_share_rate = r_allowed_out;

    psrl_tbl #(
        .FLOW_SLOTS (FLOW_SLOTS),
        .IDX_W      (IDX_W)
    ) u_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (tbl_rd_en),
        .i_rd_idx (IDX_W'(i_flow_id)),
        .o_rd_rec (tbl_rec),
        .i_wr_en  (tbl_wr_en),
        .i_wr_idx (r_idx),
        .i_wr_rec (wr_rec)
    );

    psrl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_acc   (mac_acc)
    );

    psrl_div #(
        .DVS_W (TOTAL_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (div_cmd),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("block still busy after its result");

    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_valid))
        else $error("busy dropped without a result");

    a_grant_non_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode != psrl_pkg::MODE_SEND) |-> o_grant)
        else $error("grant withheld on a non-send command");

endmodule

>>> hw/rtl/psrl_tbl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table
// One synchronous memory of flow records with a registered read; entries
// never written read as zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module psrl_tbl #(
    parameter int FLOW_SLOTS = psrl_pkg::FLOW_SLOTS_DEF,
    parameter int IDX_W      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output psrl_pkg::t_flow_rec  o_rd_rec,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_idx,
    input  psrl_pkg::t_flow_rec  i_wr_rec
);

    psrl_pkg::t_flow_rec       r_mem [FLOW_SLOTS];
    logic [FLOW_SLOTS-1:0]     r_valid;
    psrl_pkg::t_flow_rec       r_rdata;
    logic                      r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_rec;
        end
        if (i_rd_en) begin
            r_rdata    <= r_mem[i_rd_idx];
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_rec = r_rd_valid ? r_rdata : '0;

endmodule

>>> hw/rtl/psrl_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// A 24 by 24 bit multiplier, registered, feeding a 96-bit accumulator with a
// shift of 0, 24 or 48 bits per partial product.
// ----------------------------------------------------------------------------
module psrl_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  psrl_pkg::t_mac_op                i_op,
    output logic [psrl_pkg::ACC_W-1:0]       o_acc
);

    logic                              r_vld;
    logic                              r_clr;
    logic [1:0]                        r_sh;
    logic [psrl_pkg::PROD_W-1:0]       r_prod;
    logic [psrl_pkg::ACC_W-1:0]        r_acc;
    logic [psrl_pkg::ACC_W-1:0]        shifted;
    logic [psrl_pkg::ACC_W-1:0]        base;

    always_comb begin
        case (r_sh)
            psrl_pkg::MAC_SH24: shifted = psrl_pkg::ACC_W'(r_prod) << 24;
            psrl_pkg::MAC_SH48: shifted = psrl_pkg::ACC_W'(r_prod) << 48;
            default:            shifted = psrl_pkg::ACC_W'(r_prod);
        endcase
        base = r_clr ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_op.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.vld) begin
            r_prod <= psrl_pkg::PROD_W'(i_op.a) * psrl_pkg::PROD_W'(i_op.b);
            r_sh   <= i_op.sh;
            r_clr  <= i_op.clr;
        end
        if (r_vld) begin
            r_acc <= base + shifted;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> hw/rtl/psrl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle; the dividend arrives
// aligned to its top bit and the step count sets the quotient width.
// ----------------------------------------------------------------------------
module psrl_div #(
    parameter int DVS_W = 52
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psrl_pkg::t_div_cmd           i_cmd,
    input  logic [DVS_W-1:0]             i_divisor,
    output logic                         o_done,
    output logic [psrl_pkg::ACC_W-1:0]   o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [psrl_pkg::STEP_W-1:0]        r_cnt;
    logic [psrl_pkg::ACC_W-1:0]         r_q;
    logic [DVS_W-1:0]                   r_rem;
    logic [DVS_W-1:0]                   r_dvs;
    logic [DVS_W:0]                     trial;
    logic [DVS_W:0]                     diff;
    logic                               ge;

    always_comb begin
        trial = {r_rem, r_q[psrl_pkg::ACC_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - psrl_pkg::STEP_W'(1);
                if (r_cnt == psrl_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q   <= i_cmd.dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[psrl_pkg::ACC_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> tb/sv/tb_proportional_share_rate_limiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Proportional share rate limiter unit testbench
// Feeds offer, send, release and unused-mode commands through the start/busy
// handshake, predicts the grant and allowed rate of each transfer with its
// own flow table model, and checks every result strobe. The rate cap,
// smoothing weight, reset trigger and limit enable are rewritten between
// phases over the APB port, including their extreme settings.
// ----------------------------------------------------------------------------
module tb_proportional_share_rate_limiter_unit;
    import psrl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                FLOWS       = 16;
    localparam int                CYCLE_LIMIT = 1000000;
    localparam int                DRAIN_WAIT  = 300;

    typedef logic [RATE_W-1:0] t_rate;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FLOW_W-1:0] flow;
        logic [BYTE_W-1:0] bytes;
        logic [TIME_W-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic  grant;
        t_rate allowed;
    } t_verdict;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic [MODE_W-1:0]  i_mode;
    logic [FLOW_W-1:0]  i_flow_id;
    logic [BYTE_W-1:0]  i_byte_count;
    logic [TIME_W-1:0]  i_time_now;
    logic               o_valid;
    logic               o_grant;
    t_rate              o_share_rate;

    proportional_share_rate_limiter_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_mode(i_mode), .i_flow_id(i_flow_id),
        .i_byte_count(i_byte_count), .i_time_now(i_time_now),
        .o_valid(o_valid), .o_grant(o_grant),
        .o_share_rate(o_share_rate)
    );

    // Shadow of the block's registers and flow table.
    t_rate                cap_q;
    logic [WEIGHT_W-1:0]  weight_q;
    logic [TRIG_W-1:0]    trigger_q;
    logic                 limit_q;
    t_rate                offered_tbl [FLOWS];
    t_rate                allowed_tbl [FLOWS];
    t_rate                send_tbl    [FLOWS];
    logic [TIME_W-1:0]    t_offer_tbl [FLOWS];
    logic [TIME_W-1:0]    t_send_tbl  [FLOWS];
    logic [63:0]          offered_sum;

    t_cmd     pending_cmds [$];
    t_verdict due_verdicts [$];
    int       errors;
    int       cycles;
    logic     feeding;
    logic     steady;
    logic [TIME_W-1:0] tick;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_rate measured_rate(logic [BYTE_W-1:0] bytes,
                                            logic [TIME_W-1:0] now,
                                            logic [TIME_W-1:0] then_t);
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       quot;
        elapsed = now - then_t;
        if (elapsed == '0)
            elapsed = TIME_W'(1);
        quot = ({32'd0, bytes} << 16) / {32'd0, elapsed};
        return (quot > {16'd0, RATE_MAX}) ? RATE_MAX : quot[RATE_W-1:0];
    endfunction

    function automatic t_rate smoothed(t_rate old_rate, t_rate fresh);
        logic [WEIGHT_W-1:0] w;
        logic [80:0]         acc;
        w   = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
        acc = {33'd0, old_rate} * (81'(WEIGHT_ONE) - 81'(w)) + {33'd0, fresh} * 81'(w);
        return acc[16 +: RATE_W];
    endfunction

    function automatic t_rate fair_share(t_rate offered);
        logic [127:0] prod;
        if (offered_sum == 0)
            return '0;
        if (cap_q == RATE_MAX || offered_sum <= {16'd0, cap_q})
            return offered;
        prod = ({80'd0, offered} * {80'd0, cap_q}) / {64'd0, offered_sum};
        return prod[RATE_W-1:0];
    endfunction

    function automatic t_verdict predict_verdict(t_cmd c);
        t_verdict    v;
        t_rate       fresh;
        t_rate       avg;
        logic [71:0] lhs;
        logic [71:0] rhs;
        v.grant = 1'b1;
        case (c.mode)
            MODE_OFFER: begin
                fresh = measured_rate(c.bytes, c.now, t_offer_tbl[c.flow]);
                avg   = smoothed(offered_tbl[c.flow], fresh);
                t_offer_tbl[c.flow] = c.now;
                offered_sum = offered_sum - offered_tbl[c.flow] + avg;
                offered_tbl[c.flow] = avg;
                allowed_tbl[c.flow] = fair_share(avg);
            end
            MODE_SEND: begin
                fresh = measured_rate(c.bytes, c.now, t_send_tbl[c.flow]);
                lhs = {24'd0, send_tbl[c.flow]} << 8;
                rhs = {24'd0, allowed_tbl[c.flow]} * {56'd0, trigger_q};
                if (lhs > rhs)
                    send_tbl[c.flow] = '0;
                avg = smoothed(send_tbl[c.flow], fresh);
                v.grant = (avg <= allowed_tbl[c.flow]) || !limit_q;
                if (v.grant) begin
                    send_tbl[c.flow]   = avg;
                    t_send_tbl[c.flow] = c.now;
                end
            end
            MODE_RELEASE: begin
                offered_sum = offered_sum - offered_tbl[c.flow];
                offered_tbl[c.flow] = '0;
                allowed_tbl[c.flow] = '0;
                send_tbl[c.flow]    = '0;
                t_offer_tbl[c.flow] = '0;
                t_send_tbl[c.flow]  = '0;
            end
            default: ;
        endcase
        v.allowed = allowed_tbl[c.flow];
        return v;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Command driver: predicts each transfer as it is accepted.
    always @(posedge i_clk) begin
        t_cmd c;
        logic taken;
        taken = start && !busy;
        if (taken)
            due_verdicts.push_back(predict_verdict({i_mode, i_flow_id, i_byte_count,
                                                    i_time_now}));
        if (!start || taken) begin
            if (feeding && pending_cmds.size() > 0 &&
                (steady || $urandom_range(99) >= 7)) begin
                c = pending_cmds.pop_front();
                i_mode       <= c.mode;
                i_flow_id    <= c.flow;
                i_byte_count <= c.bytes;
                i_time_now   <= c.now;
                start        <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_valid) begin
            if (due_verdicts.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                v = due_verdicts.pop_front();
                if (o_grant !== v.grant)
                    report_mismatch($sformatf("grant %0b, expected %0b",
                                              o_grant, v.grant));
                if (o_share_rate !== v.allowed)
                    report_mismatch($sformatf("share rate %0h, expected %0h",
                                              o_share_rate, v.allowed));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** proportional_share_rate_limiter_unit: FAILED **");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] index, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            CFG_RATE_CAP: cap_q     = value[RATE_W-1:0];
            CFG_WEIGHT:   weight_q  = value[WEIGHT_W-1:0];
            CFG_TRIGGER:  trigger_q = value[TRIG_W-1:0];
            default:      limit_q   = value[0];
        endcase
    endtask

    task automatic configure(t_rate cap, logic [WEIGHT_W-1:0] w,
                             logic [TRIG_W-1:0] trig, logic en);
        reg_write(CFG_RATE_CAP, {16'd0, cap});
        reg_write(CFG_WEIGHT, {47'd0, w});
        reg_write(CFG_TRIGGER, {48'd0, trig});
        reg_write(CFG_LIMIT_EN, {63'd0, en});
    endtask

    task automatic drain;
        while (pending_cmds.size() > 0 || start || busy || due_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic push_cmd(logic [MODE_W-1:0] m, logic [FLOW_W-1:0] f,
                            logic [BYTE_W-1:0] b, logic [TIME_W-1:0] t);
        pending_cmds.push_back({m, f, b, t});
    endtask

    // Mostly well-formed traffic on a few flows with a moving clock, with some
    // noise at full field range.
    task automatic random_traffic(int count);
        int                r;
        logic [MODE_W-1:0] m;
        logic [FLOW_W-1:0] f;
        logic [BYTE_W-1:0] b;
        repeat (count) begin
            r = $urandom_range(99);
            f = ($urandom_range(3) == 0) ? FLOW_W'($urandom) : FLOW_W'($urandom_range(3));
            m = (r < 45) ? MODE_OFFER : (r < 88) ? MODE_SEND :
                (r < 95) ? MODE_RELEASE : MODE_UNUSED;
            tick += $urandom_range(2000);
            b = $urandom_range(6000);
            if ($urandom_range(19) == 0) begin
                b = $urandom;
                push_cmd(m, f, b, $urandom);
            end else begin
                push_cmd(m, f, b, tick);
            end
        end
    endtask

    initial begin
        errors       = 0;
        cycles       = 0;
        feeding      = 1'b0;
        steady       = 1'b0;
        tick         = '0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_mode       = '0;
        i_flow_id    = '0;
        i_byte_count = '0;
        i_time_now   = '0;
        cap_q        = RST_RATE_CAP;
        weight_q     = RST_WEIGHT;
        trigger_q    = RST_TRIGGER;
        limit_q      = 1'b1;
        offered_sum  = '0;
        for (int i = 0; i < FLOWS; i++) begin
            offered_tbl[i] = '0;
            allowed_tbl[i] = '0;
            send_tbl[i]    = '0;
            t_offer_tbl[i] = '0;
            t_send_tbl[i]  = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        feeding = 1'b1;

        // Directed: reset settings, extremes of bytes and elapsed time.
        push_cmd(MODE_SEND, 4'd0, 32'd100, 32'd0);
        push_cmd(MODE_OFFER, 4'd0, 32'hFFFF_FFFF, 32'd0);
        push_cmd(MODE_OFFER, 4'd1, 32'd0, 32'hFFFF_FFFF);
        push_cmd(MODE_OFFER, 4'd15, 32'd5000, 32'd10);
        push_cmd(MODE_SEND, 4'd15, 32'd1, 32'd11);
        push_cmd(MODE_SEND, 4'd15, 32'hFFFF_FFFF, 32'd11);
        push_cmd(MODE_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(MODE_RELEASE, 4'd0, 32'd0, 32'd0);
        push_cmd(MODE_RELEASE, 4'd7, 32'd0, 32'd0);
        drain();

        // Weight above one, zero trigger, tight cap.
        configure(48'd1000, 17'h1FFFF, 16'd0, 1'b1);
        push_cmd(MODE_OFFER, 4'd2, 32'd4000, 32'd20);
        push_cmd(MODE_OFFER, 4'd3, 32'd9000, 32'd25);
        push_cmd(MODE_SEND, 4'd2, 32'd10, 32'd40);
        push_cmd(MODE_SEND, 4'd2, 32'd10, 32'd900);
        push_cmd(MODE_RELEASE, 4'd3, 32'd0, 32'd0);
        push_cmd(MODE_OFFER, 4'd2, 32'd4000, 32'd30);
        drain();

        // Zero cap, zero weight, largest trigger, limit off.
        configure(48'd0, 17'd0, 16'hFFFF, 1'b0);
        push_cmd(MODE_OFFER, 4'd4, 32'd100, 32'd5);
        push_cmd(MODE_SEND, 4'd4, 32'hFFFF_FFFF, 32'd6);
        push_cmd(MODE_UNUSED, 4'd4, 32'd0, 32'd0);
        drain();

        configure(RST_RATE_CAP, RST_WEIGHT, RST_TRIGGER, 1'b1);
        random_traffic(160);
        drain();
        configure(48'h20_0000, 17'd30000, 16'd300, 1'b1);
        random_traffic(160);
        drain();
        steady = 1'b1;
        configure(48'h1_0000, WEIGHT_ONE, 16'd256, 1'b1);
        random_traffic(160);
        drain();
        steady = 1'b0;
        configure(RATE_MAX - 1, 17'd1, 16'hFFFF, 1'b0);
        random_traffic(150);
        drain();
        configure(t_rate'({$urandom, $urandom}) >> $urandom_range(47),
                  17'($urandom_range(65536)), 16'($urandom), 1'b1);
        random_traffic(150);
        drain();
        configure(48'd3000, 17'd20000, 16'd0, 1'b1);
        random_traffic(150);
        drain();

        if (errors == 0) begin
            $display("** proportional_share_rate_limiter_unit: PASSED **");
        end else begin
            $display("** proportional_share_rate_limiter_unit: FAILED **");
        end
        $finish;
    end

endmodule
